/* hdl/kqt_pkg.sv */
// Shared types and constants for the keyed quantity table.
package kqt_pkg;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned MAX_DUMP     = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOT_W       = 6;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic rd_en;
    logic wr_key;
    logic wr_qty;
  } mem_ctrl_t;

endpackage

/* hdl/kqt_store.sv */
// Key and quantity memories: one write port, one registered read port.
module kqt_store #(
  parameter int unsigned TableDepth = kqt_pkg::TABLE_DEPTH,
  parameter int unsigned AddrW      = 6
) (
  input  logic                            clk_i,
  input  kqt_pkg::mem_ctrl_t              ctrl_i,
  input  logic [AddrW-1:0]                rd_addr_i,
  input  logic [AddrW-1:0]                wr_addr_i,
  input  logic [kqt_pkg::DATA_W-1:0]      wr_key_i,
  input  logic [kqt_pkg::DATA_W-1:0]      wr_qty_i,
  output logic [kqt_pkg::DATA_W-1:0]      rd_key_o,
  output logic [kqt_pkg::DATA_W-1:0]      rd_qty_o
);
  import kqt_pkg::*;

  logic [DATA_W-1:0] key_mem [TableDepth];
  logic [DATA_W-1:0] qty_mem [TableDepth];
  logic [DATA_W-1:0] rd_key_q;
  logic [DATA_W-1:0] rd_qty_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_key) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (ctrl_i.wr_qty) begin
      qty_mem[wr_addr_i] <= wr_qty_i;
    end
    if (ctrl_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr_i];
      rd_qty_q <= qty_mem[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_qty_o = rd_qty_q;

endmodule

/* hdl/keyed_quantity_table.sv */
// Keyed quantity table top level: request sequencer, scan and output register.
//
// A table of TableDepth (key, quantity) entries held in a synchronous memory
// pair and kept in insertion order. One request is taken at a time. Insert,
// search and update walk the stored entries one memory read per cycle; an
// update then writes back the saturated sum, and an insert into a full table
// gets a full status without a scan. A dump reads one entry at a time through
// the read, wait and emit states, one result each (at most 64; an empty table
// gives one not-found result). A finished result sits in the output register,
// so the next request can be accepted while it waits.
module keyed_quantity_table #(
  parameter int unsigned TableDepth = kqt_pkg::TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  kqt_pkg::action_e                    action_i,
  input  logic signed [kqt_pkg::DATA_W-1:0]   part_key_i,
  input  logic signed [kqt_pkg::DATA_W-1:0]   amount_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kqt_pkg::status_e                    status_o,
  output logic signed [kqt_pkg::DATA_W-1:0]   entry_key_o,
  output logic signed [kqt_pkg::DATA_W-1:0]   entry_quantity_o,
  output logic [kqt_pkg::SLOT_W-1:0]          entry_slot_o,
  output logic                                last_result_o
);
  import kqt_pkg::*;

  localparam int unsigned AddrW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW    = $clog2(TableDepth + 1);
  localparam int unsigned DumpMax = (TableDepth < MAX_DUMP) ? TableDepth : MAX_DUMP;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_ADD     = 6'b000100,
    S_DUMP_RD = 6'b001000,
    S_DUMP_WT = 6'b010000,
    S_EMIT    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  action_e           op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] amt_q, amt_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_idx_q, pend_idx_d;

  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_key_q, res_key_d;
  logic [DATA_W-1:0] res_qty_q, res_qty_d;
  logic [AddrW-1:0]  res_idx_q, res_idx_d;
  logic              res_last_q, res_last_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_key_q;
  logic [DATA_W-1:0] out_qty_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;
  logic              out_load;

  mem_ctrl_t         mem_ctrl;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_key;
  logic [DATA_W-1:0] wr_qty;
  logic [DATA_W-1:0] rd_key;
  logic [DATA_W-1:0] rd_qty;

  logic              match;
  logic [CntW-1:0]   dump_n;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_sat;

  kqt_store #(
    .TableDepth (TableDepth),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_qty_i  (wr_qty),
    .rd_key_o  (rd_key),
    .rd_qty_o  (rd_qty)
  );

  assign match  = pend_q && (rd_key == key_q);
  assign dump_n = (cnt_q > CntW'(DumpMax)) ? CntW'(DumpMax) : cnt_q;
  assign sum    = {rd_qty[DATA_W-1], rd_qty} + {amt_q[DATA_W-1], amt_q};
  assign sum_sat = (sum[DATA_W] == sum[DATA_W-1]) ? sum[DATA_W-1:0] :
                   (sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                : {1'b0, {(DATA_W-1){1'b1}}});

  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    amt_d        = amt_q;
    cnt_d        = cnt_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_qty_d    = res_qty_q;
    res_idx_d    = res_idx_q;
    res_last_d   = res_last_q;
    mem_ctrl     = '0;
    rd_addr      = scan_q[AddrW-1:0];
    wr_addr      = cnt_q[AddrW-1:0];
    wr_key       = key_q;
    wr_qty       = amt_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = action_i;
          key_d      = part_key_i;
          amt_d      = amount_i;
          scan_d     = '0;
          pend_d     = 1'b0;
          res_last_d = 1'b1;
          if (action_i == ACT_DUMP) begin
            if (dump_n == '0) begin
              res_status_d = ST_NOT_FOUND;
              res_key_d    = '0;
              res_qty_d    = '0;
              res_idx_d    = '0;
              state_d      = S_EMIT;
            end else begin
              state_d = S_DUMP_RD;
            end
          end else if ((action_i == ACT_INSERT) && (cnt_q == CntW'(TableDepth))) begin
            res_status_d = ST_FULL;
            res_key_d    = '0;
            res_qty_d    = '0;
            res_idx_d    = '0;
            state_d      = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          pend_d       = 1'b0;
          res_status_d = (op_q == ACT_INSERT) ? ST_DUPLICATE : ST_OK;
          res_key_d    = rd_key;
          res_qty_d    = rd_qty;
          res_idx_d    = pend_idx_q;
          state_d      = (op_q == ACT_UPDATE) ? S_ADD : S_EMIT;
        end else if (scan_q == cnt_q) begin
          pend_d = 1'b0;
          if (op_q == ACT_INSERT) begin
            mem_ctrl.wr_key = 1'b1;
            mem_ctrl.wr_qty = 1'b1;
            res_status_d    = ST_OK;
            res_key_d       = key_q;
            res_qty_d       = amt_q;
            res_idx_d       = cnt_q[AddrW-1:0];
            cnt_d           = cnt_q + 1'b1;
          end else begin
            res_status_d = ST_NOT_FOUND;
            res_key_d    = '0;
            res_qty_d    = '0;
            res_idx_d    = '0;
          end
          state_d = S_EMIT;
        end else begin
          mem_ctrl.rd_en = 1'b1;
          pend_d         = 1'b1;
          pend_idx_d     = scan_q[AddrW-1:0];
          scan_d         = scan_q + 1'b1;
        end
      end

      S_ADD: begin
        mem_ctrl.wr_qty = 1'b1;
        wr_addr         = res_idx_q;
        wr_qty          = sum_sat;
        res_qty_d       = sum_sat;
        state_d         = S_EMIT;
      end

      S_DUMP_RD: begin
        mem_ctrl.rd_en = 1'b1;
        pend_idx_d     = scan_q[AddrW-1:0];
        scan_d         = scan_q + 1'b1;
        state_d        = S_DUMP_WT;
      end

      S_DUMP_WT: begin
        res_status_d = ST_OK;
        res_key_d    = rd_key;
        res_qty_d    = rd_qty;
        res_idx_d    = pend_idx_q;
        res_last_d   = (scan_q == dump_n);
        state_d      = S_EMIT;
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = ((op_q == ACT_DUMP) && !res_last_q) ? S_DUMP_RD : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    amt_q        <= amt_d;
    scan_q       <= scan_d;
    pend_idx_q   <= pend_idx_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_qty_q    <= res_qty_d;
    res_idx_q    <= res_idx_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_qty_q    <= res_qty_q;
      out_slot_q   <= SLOT_W'(res_idx_q);
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_key_o      = out_key_q;
  assign entry_quantity_o = out_qty_q;
  assign entry_slot_o     = out_slot_q;
  assign last_result_o    = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_d != cnt_q) |-> ((cnt_d == cnt_q + 1'b1) && (op_q == ACT_INSERT)))
    else $error("entry count moved other than by one insert");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted twice in a row");

  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctrl.rd_en && (mem_ctrl.wr_key || mem_ctrl.wr_qty)))
    else $error("memory read and write in the same cycle");
`endif

endmodule
